// ----- src/egcd_pkg.sv -----
// shared types and constants for the extended gcd unit
package egcd_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DOWN_NEXT,
      ST_UP_MUL,
      ST_UP_FIX,
      ST_DONE
   } state_type;

   localparam int unsigned FIELD_WIDTH = 64;

endpackage

// ----- src/extended_gcd_unit_top.sv -----
// extended gcd unit: iterative euclid with shared serial divider and multiplier
// descends through at most 2*DATA_WIDTH+2 euclid steps, storing each quotient, then
// climbs back up through them; each step down uses the serial shift-subtract divider
// and each step up the serial shift-add multiplier, both one bit per cycle
// one request at a time; req_tready is low until the result is taken
// reset (synchronous, active high) returns the sequencer to idle
module extended_gcd_unit_top
   import egcd_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // operand_a [63:0], operand_b [127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata    // gcd_value [63:0], coeff_x [127:64], coeff_y [191:128]
);

   localparam int W       = DATA_WIDTH;
   localparam int STEPS   = 2 * DATA_WIDTH + 2;
   localparam int SW      = $clog2(STEPS + 1);
   localparam int CW      = $clog2(DATA_WIDTH + 1);
   localparam int IW      = $clog2(DATA_WIDTH);

   state_type state_ff, state_in;

   logic [W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [W-1:0]  d_ff, d_in, x_ff, x_in, y_ff, y_in;
   logic [SW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // divider and multiplier registers
   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [191:0]  out_ff, out_in;

   // quotient stack
   logic [W-1:0]  qmem [STEPS];
   logic [W-1:0]  qrd_ff;
   logic          qwe;
   logic [W-1:0]  qwd;
   logic [SW-1:0] qaddr;

   logic          a_neg, b_neg;
   logic [W-1:0]  ma, mb, qsigned;
   logic [W:0]    trial;
   logic [W-1:0]  rem_sh;

   assign a_neg   = a_ff[W-1];
   assign b_neg   = b_ff[W-1];
   assign ma      = a_neg ? (~a_ff + 1'b1) : a_ff;
   assign mb      = b_neg ? (~b_ff + 1'b1) : b_ff;
   assign rem_sh  = {rem_ff[W-2:0], quo_ff[W-1]};
   assign trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
   assign qsigned = (a_neg != b_neg) ? (~quo_ff + 1'b1) : quo_ff;

   // quotient stack write and registered read
   always_ff @(posedge clock) begin
      if (qwe) begin
         qmem[qaddr] <= qwd;
      end
      qrd_ff <= qmem[qaddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_DOWN_NEXT;
         ST_DOWN_NEXT: if (a_ff == '0 || k_ff == SW'(STEPS)) begin
                          state_in = (k_ff == '0) ? ST_DONE : ST_UP_MUL;
                       end else begin
                          state_in = ST_DIV_START;
                       end
         ST_DIV_START: state_in = ST_DIV_RUN;
         ST_DIV_RUN:   if (cnt_ff == CW'(W - 1)) state_in = ST_DOWN_NEXT;
         ST_UP_MUL:    if (cnt_ff == CW'(W)) state_in = ST_UP_FIX;
         ST_UP_FIX:    state_in = (k_ff == SW'(1)) ? ST_DONE : ST_UP_MUL;
         ST_DONE:      if (rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      a_in   = a_ff;   b_in   = b_ff;
      d_in   = d_ff;   x_in   = x_ff;   y_in = y_ff;
      k_in   = k_ff;   cnt_in = cnt_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff;
      acc_in = acc_ff; out_in = out_ff;
      qwe    = 1'b0;
      qwd    = qsigned;
      qaddr  = k_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            a_in = req_tdata[W-1:0];
            b_in = req_tdata[64 +: W];
            k_in = '0;
         end
         ST_DOWN_NEXT: begin
            if (a_ff == '0 || k_ff == SW'(STEPS)) begin
               d_in  = b_ff;
               x_in  = '0;
               y_in  = W'(1);
               cnt_in = '0;
               acc_in = '0;
               qaddr = k_ff - 1'b1;
            end
         end
         ST_DIV_START: begin
            rem_in = '0;
            quo_in = mb;
            dvs_in = ma;
            cnt_in = '0;
         end
         ST_DIV_RUN: begin
            // one restoring divide step per cycle
            if (!trial[W]) begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               qwe  = 1'b1;
               qwd  = (a_neg != b_neg) ? (~quo_in + 1'b1) : quo_in;
               b_in = a_ff;
               a_in = b_neg ? (~rem_in + 1'b1) : rem_in;
               k_in = k_ff + 1'b1;
               cnt_in = '0;
            end
         end
         ST_UP_MUL: begin
            // shift-add multiply q * x, one bit per cycle
            qaddr = k_ff - 1'b1;
            if (cnt_ff != CW'(W)) begin
               if (qrd_ff[cnt_ff[IW-1:0]]) begin
                  acc_in = acc_ff + (x_ff << cnt_ff);
               end
            end
            cnt_in = cnt_ff + 1'b1;
         end
         ST_UP_FIX: begin
            x_in = y_ff - acc_ff;
            y_in = x_ff;
            if (d_ff[W-1]) begin
               d_in = ~d_ff + 1'b1;
               x_in = ~(y_ff - acc_ff) + 1'b1;
               y_in = ~x_ff + 1'b1;
            end
            k_in   = k_ff - 1'b1;
            qaddr  = k_ff - SW'(2);
            cnt_in = '0;
            acc_in = '0;
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
         end
         default: ;
      endcase
      if (state_in == ST_DONE && state_ff != ST_DONE) begin
         out_in = {FIELD_WIDTH'($signed(y_in)),
                   FIELD_WIDTH'($signed(x_in)),
                   FIELD_WIDTH'($signed(d_in))};
      end
   end

   assign rsp_tdata = out_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;   b_ff <= b_in;
      d_ff <= d_in;   x_ff <= x_in;   y_ff <= y_in;
      k_ff <= k_in;   cnt_ff <= cnt_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in;
      acc_ff <= acc_in; out_ff <= out_in;
   end

   logic unused_ok;
   assign unused_ok = ^{req_tdata[127:64], req_tdata[63:0]};

endmodule

// ----- test/egcd_checker.sv -----
// checker for the extended gcd unit: predicts each result and compares it
`timescale 1ns / 1ps

module egcd_checker #(
   parameter int DATA_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // operand_a [63:0], operand_b [127:64]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [191:0] rsp_tdata,   // gcd_value [63:0], coeff_x [127:64], coeff_y [191:128]
   output int           fail_count,
   output int           pending_count
);

   localparam int MAX_STEPS = 2 * DATA_WIDTH + 2;

   typedef struct packed {
      logic [63:0] coeff_y;
      logic [63:0] coeff_x;
      logic [63:0] gcd_value;
   } bezout_t;

   bezout_t bezout_queue[$];

   // reduce to DATA_WIDTH bits and sign-extend
   function automatic logic [63:0] fit(input logic [63:0] v);
      logic [63:0] m;
      m = (DATA_WIDTH >= 64) ? '1 : ((64'd1 << DATA_WIDTH) - 64'd1);
      v = v & m;
      if (DATA_WIDTH < 64 && v[DATA_WIDTH-1]) v = v | ~m;
      return v;
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   // extended euclid, descent then ascent with sign fix
   function automatic bezout_t solve_bezout(input logic [63:0] op_a, input logic [63:0] op_b);
      logic [63:0] quot[MAX_STEPS];
      logic [63:0] a, b, d, x, y, xx, qm, rm, q, r;
      int k;
      bezout_t res;
      a = fit(op_a);
      b = fit(op_b);
      k = 0;
      while (a != 0 && k < MAX_STEPS) begin
         qm = mag(b) / mag(a);
         rm = mag(b) % mag(a);
         q = (a[63] != b[63]) ? (64'd0 - qm) : qm;
         r = b[63] ? (64'd0 - rm) : rm;
         quot[k] = fit(q);
         k++;
         b = a;
         a = fit(r);
      end
      d = b;
      x = 0;
      y = 1;
      for (int i = k - 1; i >= 0; i--) begin
         xx = x;
         x = fit(y - quot[i] * xx);
         y = xx;
         if (d[63]) begin
            d = fit(64'd0 - d);
            x = fit(64'd0 - x);
            y = fit(64'd0 - y);
         end
      end
      res.gcd_value = d;
      res.coeff_x = x;
      res.coeff_y = y;
      return res;
   endfunction

   assign pending_count = bezout_queue.size();

   // record requests and compare responses
   always @(posedge clock) begin
      bezout_t got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            bezout_queue.insert(bezout_queue.size(),
                                solve_bezout(req_tdata[63:0], req_tdata[127:64]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (bezout_queue.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = bezout_queue.pop_front();
               if (got.gcd_value !== want.gcd_value)
                  $error("gcd_value expected %h actual %h", want.gcd_value, got.gcd_value);
               if (got.coeff_x !== want.coeff_x)
                  $error("coeff_x expected %h actual %h", want.coeff_x, got.coeff_x);
               if (got.coeff_y !== want.coeff_y)
                  $error("coeff_y expected %h actual %h", want.coeff_y, got.coeff_y);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

// ----- test/tb.sv -----
// testbench top for the extended gcd unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb;

   localparam int DATA_WIDTH = 64;
   localparam int NUM_RANDOM = 80;
   localparam int IDLE_LIMIT = 200000;
   localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0001;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [191:0] rsp_tdata;
   int           fail_count;
   int           pending_count;
   bit           stim_done = 0;
   int           idle_cycles = 0;

   extended_gcd_unit_top #(.DATA_WIDTH(DATA_WIDTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   egcd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
   endfunction

   // random operand: full range, small values of either sign, shifted-down values, or near extremes
   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      case ($urandom_range(0, 4))
         0: v = {$urandom, $urandom};
         1: v = $urandom_range(0, 1000);
         2: v = 64'd0 - $urandom_range(0, 1000);
         3: v = {$urandom, $urandom} >> $urandom_range(1, 62);
         default: v = ($urandom_range(0, 1) == 1) ? MAX_POS - $urandom_range(0, 5)
                                                  : MIN_NEG + $urandom_range(0, 5);
      endcase
      if (v == 64'h8000_0000_0000_0000) v = MIN_NEG;
      return v;
   endfunction

   task automatic send_request(input logic [63:0] op_a, input logic [63:0] op_b);
      req_tdata  <= {op_b, op_a};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
   endtask

   // request side
   initial begin
      logic [63:0] dir_a[$];
      logic [63:0] dir_b[$];
      int g;
      dir_a = '{64'd0, 64'd0, 64'd0, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG, 64'd12,
                -64'sd12, 64'd12, -64'sd12, 64'd1, -64'sd1, 64'd7, 64'd5,
                MAX_POS, 64'd240, 64'hffff_ffff_ffff_fffe, 64'h5555_5555_5555_5555,
                64'haaaa_aaaa_aaaa_aaab};
      dir_b = '{64'd0, 64'd9, -64'sd9, MAX_POS, MIN_NEG, MIN_NEG, MAX_POS, 64'd18,
                64'd18, -64'sd18, -64'sd18, MAX_POS, MIN_NEG, 64'd0, -64'sd0,
                MAX_POS - 1, 64'd46, 64'h3, 64'h3333_3333_3333_3333,
                64'hcccc_cccc_cccc_cccd};
      repeat (2) @(posedge clock);
      reset <= 0;
      foreach (dir_a[i]) begin
         send_request(dir_a[i], dir_b[i]);
         g = gap_len();
         if (g > 0) begin
            req_tvalid <= 0;
            repeat (g) @(posedge clock);
         end
      end
      // fibonacci-like pair for the deepest descent
      send_request(64'd7540113804746346429, 64'd4660046610375530309);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         send_request(rand_operand(), rand_operand());
         g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
         if (g > 0) begin
            req_tvalid <= 0;
            repeat (g) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      @(posedge clock);
      stim_done = 1;
   end

   // response side with one long hold-off early on
   initial begin
      int g;
      @(negedge reset);
      repeat (40) @(posedge clock);
      repeat (3000) @(posedge clock);
      forever begin
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
      end
   end

   // watchdog and verdict
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (stim_done && pending_count == 0) begin
            repeat (100) @(posedge clock);
            if (fail_count == 0) $display("PASS");
            else $display("FAIL");
            $finish;
         end
      end
   end

endmodule

// ----- extended_gcd_unit_top.f -----
src/egcd_pkg.sv
src/extended_gcd_unit_top.sv
test/egcd_checker.sv
test/tb.sv
